FILE: design/sgrm_pkg.sv
// Shared types and constants for the scatter-gather read mapper.
// Used by the controller, the datapath and the top level; no dependencies.
package sgrm_pkg;

  localparam int DEF_BLOCK_ENTRIES = 1024;
  localparam int DEF_FILE_COUNT    = 32;
  localparam int DEF_MAX_CHUNKS    = 64;

  localparam int IN_DATA_W  = 232;
  localparam int OUT_DATA_W = 200;
  localparam int CFG_IDX_W  = 8;
  localparam int CFG_DATA_W = 48;

  localparam logic [CFG_IDX_W-1:0] REG_TOTAL_LENGTH = 8'd0;
  localparam logic [CFG_IDX_W-1:0] REG_BLOCK_COUNT  = 8'd1;

  typedef enum logic [1:0] {
    CMD_LOAD = 2'd0,
    CMD_SEQ  = 2'd1,
    CMD_POS  = 2'd2,
    CMD_SEEK = 2'd3
  } cmd_t;

  // seek modes; the spare code behaves as from-start
  localparam logic [1:0] SMODE_ABS  = 2'd0;
  localparam logic [1:0] SMODE_REL  = 2'd1;
  localparam logic [1:0] SMODE_BACK = 2'd2;
  localparam logic [1:0] SMODE_RSVD = 2'd3;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_LOAD,
    ST_SEEK,
    ST_RSTART,
    ST_RLOOP,
    ST_RWAIT,
    ST_RCMP,
    ST_REMIT,
    ST_RFIN,
    ST_ORD,
    ST_OSHOW
  } state_t;

  // controller -> datapath
  typedef struct packed {
    logic take_item;
    logic do_load;
    logic do_seek;
    logic rd_init;
    logic tbl_read;
    logic cmp_capture;
    logic step_back;
    logic step_fwd;
    logic hit_capture;
    logic emit;
    logic set_err;
    logic rd_finish;
    logic out_load;
  } dp_ctl_t;

  // datapath -> controller
  typedef struct packed {
    cmd_t cmd;
    logic past_end;
    logic loop_go;
    logic walk_fail;
    logic below;
    logic above;
    logic out_busy;
    logic out_is_last;
  } dp_sts_t;

endpackage

FILE: design/sgrm_ram.sv
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies.
module sgrm_ram #(
  parameter int WIDTH  = 8,
  parameter int DEPTH  = 16,
  parameter int ADDR_W = $clog2(DEPTH)
) (
  input  logic              clk,
  input  logic              we,
  input  logic [ADDR_W-1:0] waddr,
  input  logic [WIDTH-1:0]  wdata,
  input  logic [ADDR_W-1:0] raddr,
  output logic [WIDTH-1:0]  rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

FILE: design/sgrm_ctrl.sv
// Controller state machine for the scatter-gather read mapper.
// Depends on sgrm_pkg; drives the datapath by a command struct.
module sgrm_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              s_tvalid,
  output logic              s_tready,
  input  sgrm_pkg::dp_sts_t sts,
  output sgrm_pkg::dp_ctl_t ctl
);
  import sgrm_pkg::*;

  state_t state, state_next;
  logic   accept;

  assign accept = s_tvalid && s_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (accept) begin
          state_next = ST_RSTART;
        end
      end
      ST_RSTART: begin
        // item registers are loaded now; branch on the command
        case (sts.cmd)
          CMD_LOAD: state_next = ST_LOAD;
          CMD_SEEK: state_next = ST_SEEK;
          default:  state_next = sts.past_end ? ST_ORD : ST_RLOOP;
        endcase
      end
      ST_LOAD:  state_next = ST_ORD;
      ST_SEEK:  state_next = ST_ORD;
      ST_RLOOP: begin
        if (!sts.loop_go || sts.walk_fail) begin
          state_next = ST_RFIN;
        end else begin
          state_next = ST_RWAIT;
        end
      end
      ST_RWAIT: state_next = ST_RCMP;
      ST_RCMP: begin
        if (sts.below || sts.above) begin
          state_next = ST_RLOOP;
        end else begin
          state_next = ST_REMIT;
        end
      end
      ST_REMIT: state_next = ST_RLOOP;
      ST_RFIN:  state_next = ST_ORD;
      ST_ORD:   state_next = ST_OSHOW;
      ST_OSHOW: begin
        if (!sts.out_busy) begin
          state_next = sts.out_is_last ? ST_IDLE : ST_ORD;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    ctl      = '0;
    s_tready = 1'b0;
    case (state)
      ST_IDLE: begin
        s_tready      = !rst;
        ctl.take_item = accept;
      end
      ST_RSTART: ctl.rd_init = 1'b1;
      ST_LOAD:   ctl.do_load = 1'b1;
      ST_SEEK:   ctl.do_seek = 1'b1;
      ST_RLOOP: begin
        if (sts.loop_go) begin
          if (sts.walk_fail) begin
            ctl.set_err = 1'b1;
          end else begin
            ctl.tbl_read = 1'b1;
          end
        end
      end
      ST_RWAIT: ctl.cmp_capture = 1'b1;
      ST_RCMP: begin
        if (sts.below) begin
          ctl.step_back = 1'b1;
        end else if (sts.above) begin
          ctl.step_fwd = 1'b1;
        end else begin
          ctl.hit_capture = 1'b1;
        end
      end
      ST_REMIT: ctl.emit = 1'b1;
      ST_RFIN:  ctl.rd_finish = 1'b1;
      ST_OSHOW: ctl.out_load = !sts.out_busy;
      default: ;
    endcase
  end
endmodule

FILE: design/sgrm_dp.sv
// Datapath: block table, walk registers, chunk buffer and output register.
// Depends on sgrm_pkg and sgrm_ram; steered by sgrm_ctrl.
module sgrm_dp #(
  parameter int BLOCK_ENTRIES = sgrm_pkg::DEF_BLOCK_ENTRIES,
  parameter int FILE_COUNT    = sgrm_pkg::DEF_FILE_COUNT,
  parameter int MAX_CHUNKS    = sgrm_pkg::DEF_MAX_CHUNKS
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic [sgrm_pkg::IN_DATA_W-1:0]    s_tdata,
  input  logic [1:0]                        s_tuser,
  input  logic                              cfg_valid,
  input  logic [sgrm_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [sgrm_pkg::CFG_DATA_W-1:0]   cfg_data,
  output logic                              m_tvalid,
  input  logic                              m_tready,
  output logic [sgrm_pkg::OUT_DATA_W-1:0]   m_tdata,
  output logic                              m_tuser,
  output logic                              m_tlast,
  input  sgrm_pkg::dp_ctl_t                 ctl,
  output sgrm_pkg::dp_sts_t                 sts
);
  import sgrm_pkg::*;

  localparam int IW  = $clog2(BLOCK_ENTRIES);
  localparam int NW  = IW + 1;
  localparam int CW  = (NW > 11) ? NW : 11;
  localparam int KW  = $clog2(MAX_CHUNKS + 1);
  localparam int CAW = (MAX_CHUNKS > 1) ? $clog2(MAX_CHUNKS) : 1;
  localparam int TW  = 48 + 32 + 5 + 48;
  localparam int BW  = 5 + 48 + 32 + 32;

  // configuration
  logic [47:0] total_length;
  logic [10:0] block_count;

  always_ff @(posedge clk) begin
    if (rst) begin
      total_length <= '0;
      block_count  <= '0;
    end else if (cfg_valid) begin
      if (cfg_index == REG_TOTAL_LENGTH) begin
        total_length <= cfg_data;
      end else if (cfg_index == REG_BLOCK_COUNT) begin
        block_count <= cfg_data[10:0];
      end
    end
  end

  // item registers
  cmd_t        it_cmd;
  logic [9:0]  it_idx;
  logic [47:0] it_start;
  logic [31:0] it_len;
  logic [4:0]  it_file;
  logic [47:0] it_foff;
  logic [48:0] it_roff;
  logic [31:0] it_count;
  logic [1:0]  it_mode;

  always_ff @(posedge clk) begin
    if (ctl.take_item) begin
      it_cmd   <= cmd_t'(s_tuser);
      it_idx   <= s_tdata[9:0];
      it_start <= s_tdata[57:10];
      it_len   <= s_tdata[89:58];
      it_file  <= s_tdata[94:90];
      it_foff  <= s_tdata[142:95];
      it_roff  <= s_tdata[191:143];
      it_count <= s_tdata[223:192];
      it_mode  <= s_tdata[225:224];
    end
  end

  logic        neg;
  logic [48:0] mag;
  assign neg = it_roff[48];
  assign mag = neg ? (~it_roff + 49'd1) : it_roff;

  // effective block count
  logic [CW-1:0] bc_ext;
  logic [NW-1:0] n;
  assign bc_ext = CW'(block_count);
  assign n = (bc_ext > CW'(BLOCK_ENTRIES)) ? NW'(BLOCK_ENTRIES) : NW'(bc_ext);

  // walk state
  logic [IW-1:0] cur_blk;
  logic [47:0]   rd_pos;
  logic [48:0]   off;
  logic [31:0]   remain;
  logic [31:0]   nread;
  logic [IW-1:0] blk;
  logic [NW-1:0] insp;
  logic [KW-1:0] kcnt;
  logic [KW-1:0] out_idx;
  logic          err;

  logic [48:0] start_off;
  assign start_off = (it_cmd == CMD_SEQ) ? {1'b0, rd_pos} : (neg ? 49'd0 : mag);

  // block table
  logic          tbl_we;
  logic [TW-1:0] tbl_wdata;
  logic [TW-1:0] tbl_rdata;
  logic [8:0]    file_ext;
  logic [4:0]    file_st;

  assign file_ext = {4'd0, it_file};
  assign file_st  = (file_ext >= 9'(FILE_COUNT)) ? 5'(FILE_COUNT - 1) : it_file;
  assign tbl_we   = ctl.do_load && (32'(it_idx) < 32'(BLOCK_ENTRIES));
  assign tbl_wdata = {it_start, it_len, file_st, it_foff};

  sgrm_ram #(.WIDTH(TW), .DEPTH(BLOCK_ENTRIES), .ADDR_W(IW)) u_tbl (
    .clk   (clk),
    .we    (tbl_we),
    .waddr (IW'(it_idx)),
    .wdata (tbl_wdata),
    .raddr (blk),
    .rdata (tbl_rdata)
  );

  // captured entry
  logic [47:0] t_start;
  logic [48:0] t_stop;
  logic [4:0]  t_file;
  logic [47:0] t_fo;
  logic [47:0] skip;
  logic [32:0] avail;
  logic [31:0] want;

  always_ff @(posedge clk) begin
    if (ctl.cmp_capture) begin
      t_start <= tbl_rdata[TW-1 -: 48];
      t_stop  <= {1'b0, tbl_rdata[TW-1 -: 48]} + 49'(tbl_rdata[84:53]);
      t_file  <= tbl_rdata[52:48];
      t_fo    <= tbl_rdata[47:0];
    end
    if (ctl.hit_capture) begin
      skip  <= 48'(off - {1'b0, t_start});
      avail <= 33'(t_stop - off);
    end
  end

  assign want = ({1'b0, remain} < avail) ? remain : avail[31:0];

  // chunk buffer
  logic [BW-1:0]  cb_wdata;
  logic [BW-1:0]  cb_rdata;
  assign cb_wdata = {t_file, t_fo + skip, want, nread};

  sgrm_ram #(.WIDTH(BW), .DEPTH(MAX_CHUNKS), .ADDR_W(CAW)) u_chunks (
    .clk   (clk),
    .we    (ctl.emit),
    .waddr (CAW'(kcnt)),
    .wdata (cb_wdata),
    .raddr (CAW'(out_idx)),
    .rdata (cb_rdata)
  );

  // seek target
  logic [49:0] seek_p;
  always_comb begin
    if (it_mode == SMODE_REL) begin
      if (neg) begin
        seek_p = ({1'b0, rd_pos} >= mag) ? 50'({1'b0, rd_pos} - mag) : 50'd0;
      end else begin
        seek_p = 50'(rd_pos) + 50'(mag);
      end
    end else if (it_mode == SMODE_BACK) begin
      if (neg) begin
        seek_p = 50'(total_length) + 50'(mag);
      end else begin
        seek_p = ({1'b0, total_length} >= mag) ? 50'({1'b0, total_length} - mag) : 50'd0;
      end
    end else begin
      seek_p = neg ? 50'd0 : 50'(mag);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cur_blk <= '0;
      rd_pos  <= '0;
      kcnt    <= '0;
      out_idx <= '0;
      err     <= 1'b0;
    end else begin
      if (ctl.rd_init) begin
        off     <= start_off;
        remain  <= it_count;
        nread   <= '0;
        insp    <= '0;
        kcnt    <= '0;
        out_idx <= '0;
        err     <= 1'b0;
        blk     <= ({1'b0, cur_blk} >= n) ? '0 : cur_blk;
      end
      if (ctl.do_seek) begin
        rd_pos <= seek_p[49:48] != 2'd0 ? 48'hFFFF_FFFF_FFFF : seek_p[47:0];
      end
      if (ctl.tbl_read) begin
        insp <= insp + NW'(1);
      end
      if (ctl.step_back) begin
        blk <= (blk == '0) ? IW'(n - NW'(1)) : blk - IW'(1);
      end
      if (ctl.step_fwd) begin
        blk <= ((NW'(blk) + NW'(1)) == n) ? '0 : blk + IW'(1);
      end
      if (ctl.emit) begin
        off    <= off + 49'(want);
        nread  <= nread + want;
        remain <= remain - want;
        kcnt   <= kcnt + KW'(1);
        insp   <= '0;
      end
      if (ctl.set_err) begin
        err <= 1'b1;
      end
      if (ctl.rd_finish) begin
        cur_blk <= blk;
        rd_pos  <= off[48] ? 48'hFFFF_FFFF_FFFF : off[47:0];
      end
      if (ctl.out_load) begin
        out_idx <= out_idx + KW'(1);
      end
    end
  end

  // result selection and output register
  logic chunks_left;
  logic need_status;
  logic out_last;
  assign chunks_left = out_idx < kcnt;
  assign need_status = err || (kcnt == '0);
  assign out_last    = chunks_left ? ((out_idx + KW'(1) == kcnt) && !need_status) : 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (ctl.out_load) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.out_load) begin
      m_tlast <= out_last;
      if (chunks_left) begin
        m_tuser <= 1'b1;
        m_tdata <= {2'b0, 1'b0,
                    cb_rdata[31:0] + cb_rdata[63:32],
                    rd_pos, cb_rdata[31:0], cb_rdata[63:32],
                    cb_rdata[111:64], cb_rdata[116:112]};
      end else begin
        m_tuser <= 1'b0;
        m_tdata <= {2'b0, err, nread, rd_pos, 32'd0, 32'd0, 48'd0, 5'd0};
      end
    end
  end

  assign sts.cmd         = it_cmd;
  assign sts.past_end    = start_off >= {1'b0, total_length};
  assign sts.loop_go     = (remain != '0) && (off < {1'b0, total_length})
                           && (kcnt < KW'(MAX_CHUNKS));
  assign sts.walk_fail   = insp >= n;
  assign sts.below       = off < {1'b0, t_start};
  assign sts.above       = off >= t_stop;
  assign sts.out_busy    = m_tvalid && !m_tready;
  assign sts.out_is_last = out_last;
endmodule

FILE: design/scatter_gather_read_mapper.sv
// Scatter-gather read mapper: one word in, one or more result words out.
// Load and seek give one status word, as does a read past the end; a read walks the table
// block by block, buffers each chunk found, then sends its results one word at a time from
// the chunk buffer, each once the output register is free. One item at a time: the next word
// is taken once the last result is registered. Reset (rst, synchronous, active high) clears
// control, configuration, cached block and position; table entries are undefined until loaded.
module scatter_gather_read_mapper #(
  parameter int BLOCK_ENTRIES = sgrm_pkg::DEF_BLOCK_ENTRIES,
  parameter int FILE_COUNT    = sgrm_pkg::DEF_FILE_COUNT,
  parameter int MAX_CHUNKS    = sgrm_pkg::DEF_MAX_CHUNKS
) (
  input  logic                              clk,
  input  logic                              rst,
  // input word
  input  logic                              s_tvalid,
  output logic                              s_tready,
  // tdata, low bit up: entry_index[9:0], entry_start[57:10], entry_length[89:58],
  // entry_file[94:90], entry_file_offset[142:95], request_offset[191:143],
  // request_count[223:192], seek_mode[225:224], zero fill
  input  logic [sgrm_pkg::IN_DATA_W-1:0]    s_tdata,
  input  logic [1:0]                        s_tuser,   // cmd
  // configuration writes, ready whenever out of reset
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [sgrm_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [sgrm_pkg::CFG_DATA_W-1:0]   cfg_data,
  // result word
  output logic                              m_tvalid,
  input  logic                              m_tready,
  // tdata, low bit up: chunk_file[4:0], chunk_file_offset[52:5],
  // chunk_length[84:53], chunk_buffer_offset[116:85], position[164:117],
  // total_bytes[196:165], walk_error[197], zero fill
  output logic [sgrm_pkg::OUT_DATA_W-1:0]   m_tdata,
  output logic                              m_tuser,   // chunk_valid
  output logic                              m_tlast
);
  import sgrm_pkg::*;

  dp_ctl_t ctl;
  dp_sts_t sts;

  assign cfg_ready = !rst;

  // controller sequences load, seek, the block walk and result drain
  sgrm_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .sts      (sts),
    .ctl      (ctl)
  );

  // datapath holds the table, walk registers and output register
  sgrm_dp #(
    .BLOCK_ENTRIES (BLOCK_ENTRIES),
    .FILE_COUNT    (FILE_COUNT),
    .MAX_CHUNKS    (MAX_CHUNKS)
  ) u_dp (
    .clk       (clk),
    .rst       (rst),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .cfg_valid (cfg_valid),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tuser   (m_tuser),
    .m_tlast   (m_tlast),
    .ctl       (ctl),
    .sts       (sts)
  );
endmodule

FILE: design/sgrm_checker.sv
// Port-level checks for the scatter-gather read mapper, bound to the top level.
// Depends on sgrm_pkg for port widths.
module sgrm_checker (
  input logic                            clk,
  input logic                            rst,
  input logic                            m_tvalid,
  input logic                            m_tready,
  input logic [sgrm_pkg::OUT_DATA_W-1:0] m_tdata,
  input logic                            m_tuser,
  input logic                            m_tlast
);
  a_reset_idle: assert property (@(posedge clk) rst |=> !m_tvalid)
    else $error("result valid after reset");

  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser)
                              && $stable(m_tlast))
    else $error("stalled result changed");

  a_err_status: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tdata[197] |-> !m_tuser && m_tlast)
    else $error("walk error not on final status word");

  a_mid_chunk: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tlast |-> m_tuser)
    else $error("status word before end of item");
endmodule

bind scatter_gather_read_mapper sgrm_checker u_chk (
  .clk      (clk),
  .rst      (rst),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata),
  .m_tuser  (m_tuser),
  .m_tlast  (m_tlast)
);

FILE: verif/scatter_gather_read_mapper_tb.sv
// Self-checking testbench for scatter_gather_read_mapper: stream driver, result monitor
// and an in-bench table-walk predictor. Depends on sgrm_pkg and the design top only.
module scatter_gather_read_mapper_tb;
  import sgrm_pkg::*;

  localparam logic [63:0] MASK48 = 64'hFFFF_FFFF_FFFF;
  localparam int          NTBL   = DEF_BLOCK_ENTRIES;

  typedef struct {
    cmd_t        cmd;
    logic [9:0]  idx;
    logic [47:0] start;
    logic [31:0] len;
    logic [4:0]  file;
    logic [47:0] foff;
    logic [48:0] roff;
    logic [31:0] cnt;
    logic [1:0]  mode;
  } item_t;

  typedef struct {
    logic        cv;
    logic [4:0]  file;
    logic [47:0] foff;
    logic [31:0] len;
    logic [31:0] boff;
    logic [47:0] pos;
    logic [31:0] total;
    logic        err;
    logic        last;
  } chunk_t;

  logic                  clk;
  logic                  rst;
  logic                  s_tvalid;
  logic                  s_tready;
  logic [IN_DATA_W-1:0]  s_tdata;
  logic [1:0]            s_tuser;
  logic                  cfg_valid;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;
  logic                  m_tvalid;
  logic                  m_tready;
  logic [OUT_DATA_W-1:0] m_tdata;
  logic                  m_tuser;
  logic                  m_tlast;

  scatter_gather_read_mapper DUT (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
    .cfg_data(cfg_data),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
    .m_tlast(m_tlast)
  );

  // mirror of the block state
  logic [47:0] tbl_start [NTBL];
  logic [31:0] tbl_len   [NTBL];
  logic [4:0]  tbl_file  [NTBL];
  logic [47:0] tbl_foff  [NTBL];
  logic [63:0] cur_blk;
  logic [63:0] rd_pos;
  logic [63:0] stream_len;
  logic [63:0] blk_count;

  item_t  pending_q [$];   // words waiting for the driver
  chunk_t chunk_q   [$];   // expected result words, oldest first
  item_t  cur_item;
  int     errors;
  bit     calm;            // no idling on either side
  int     hold_asked, hold_done, hold_cnt;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #50_000_000;
    $display("FAIL scatter_gather_read_mapper");
    $finish;
  end

  // Walks the mirrored table exactly as the block does and queues the result words.
  task automatic map_item(input item_t it);
    chunk_t      rq[$];
    chunk_t      r;
    logic [48:0] mag;
    logic        neg, err;
    logic [63:0] off, remain, nread, n, blk, inspected, st, sp, want, p;
    neg = it.roff[48];
    mag = neg ? (~it.roff + 49'd1) : it.roff;
    r = '{default: '0};
    err = 1'b0;
    case (it.cmd)
      CMD_LOAD: begin
        tbl_start[it.idx] = it.start;
        tbl_len[it.idx]   = it.len;
        tbl_file[it.idx]  = it.file;   // 5-bit field never exceeds the file count
        tbl_foff[it.idx]  = it.foff;
        rq.push_back(r);
      end
      CMD_SEEK: begin
        if (it.mode == SMODE_REL)
          p = neg ? (rd_pos >= mag ? rd_pos - mag : 64'd0) : rd_pos + mag;
        else if (it.mode == SMODE_BACK)
          p = neg ? stream_len + mag : (stream_len >= mag ? stream_len - mag : 64'd0);
        else
          p = neg ? 64'd0 : 64'(mag);  // spare mode behaves as from-start
        rd_pos = p > MASK48 ? MASK48 : p;
        rq.push_back(r);
      end
      default: begin
        off = (it.cmd == CMD_SEQ) ? rd_pos : (neg ? 64'd0 : 64'(mag));
        if (off >= stream_len) begin
          rq.push_back(r);
        end else begin
          n = blk_count > 64'(NTBL) ? 64'(NTBL) : blk_count;
          blk = cur_blk >= n ? 64'd0 : cur_blk;   // stale cached block restarts at 0
          remain = 64'(it.cnt);
          nread = 0;
          inspected = 0;
          while (remain > 0 && off < stream_len) begin
            if (rq.size() >= DEF_MAX_CHUNKS) break;
            if (inspected >= n) begin
              err = 1'b1;
              break;
            end
            inspected++;
            st = 64'(tbl_start[blk]);
            sp = st + 64'(tbl_len[blk]);
            if (off < st) blk = (blk + n - 1) % n;
            else if (off >= sp) blk = (blk + 1) % n;
            else begin
              want = remain < (sp - off) ? remain : (sp - off);
              r.cv    = 1'b1;
              r.file  = tbl_file[blk];
              r.foff  = 48'(64'(tbl_foff[blk]) + (off - st));   // wraps at 48 bits
              r.len   = 32'(want);
              r.boff  = 32'(nread);
              r.total = 32'(nread + want);
              rq.push_back(r);
              off += want;
              nread += want;
              remain -= want;
              inspected = 0;
            end
          end
          cur_blk = blk;
          rd_pos = off > MASK48 ? MASK48 : off;
          if (err || rq.size() == 0) begin
            r = '{default: '0};
            r.total = 32'(nread);
            r.err = err;
            rq.push_back(r);
          end
        end
      end
    endcase
    foreach (rq[i]) begin
      rq[i].pos = 48'(rd_pos);
      rq[i].last = (i == rq.size() - 1);
      chunk_q.push_back(rq[i]);
    end
  endtask

  // --- word construction: unused fields carry random junk ---
  function automatic logic [47:0] rand48();
    return 48'({$urandom, $urandom});
  endfunction

  function automatic item_t junk_item(cmd_t c);
    item_t it;
    it.cmd = c;
    it.idx = 10'($urandom);
    it.start = rand48();
    it.len = $urandom;
    it.file = 5'($urandom);
    it.foff = rand48();
    it.roff = 49'({$urandom, $urandom});
    it.cnt = $urandom;
    it.mode = 2'($urandom);
    return it;
  endfunction

  function automatic item_t mk_load(logic [9:0] idx, logic [47:0] st, logic [31:0] len,
                                    logic [4:0] file, logic [47:0] foff);
    item_t it;
    it = junk_item(CMD_LOAD);
    it.idx = idx;
    it.start = st;
    it.len = len;
    it.file = file;
    it.foff = foff;
    return it;
  endfunction

  function automatic item_t mk_read(cmd_t c, logic [48:0] off, logic [31:0] cnt);
    item_t it;
    it = junk_item(c);
    it.roff = off;
    it.cnt = cnt;
    return it;
  endfunction

  function automatic item_t mk_seek(logic [1:0] mode, logic [48:0] off);
    item_t it;
    it = junk_item(CMD_SEEK);
    it.mode = mode;
    it.roff = off;
    return it;
  endfunction

  // --- input driver: holds each word until taken, predicts on acceptance ---
  always @(posedge clk) begin
    if (rst) begin
      s_tvalid <= 1'b0;
      s_tdata  <= '0;
      s_tuser  <= CMD_LOAD;
    end else if (!s_tvalid || s_tready) begin
      if (s_tvalid) map_item(cur_item);
      if (pending_q.size() != 0 && (calm || $urandom_range(0, 99) >= 19)) begin
        cur_item = pending_q.pop_front();
        s_tvalid <= 1'b1;
        s_tuser  <= cur_item.cmd;
        s_tdata  <= {6'd0, cur_item.mode, cur_item.cnt, cur_item.roff, cur_item.foff,
                     cur_item.file, cur_item.len, cur_item.start, cur_item.idx};
      end else begin
        s_tvalid <= 1'b0;
      end
    end
  end

  // --- receiver ready: random idling plus a long hold-off on request ---
  always @(posedge clk) begin
    if (rst) begin
      m_tready  <= 1'b0;
      hold_cnt  <= 0;
      hold_done <= 0;
    end else if (hold_asked != hold_done) begin
      hold_done <= hold_asked;
      hold_cnt  <= 400;
      m_tready  <= 1'b0;
    end else if (hold_cnt > 0) begin
      hold_cnt <= hold_cnt - 1;
      m_tready <= 1'b0;
    end else begin
      m_tready <= calm || $urandom_range(0, 99) >= 19;
    end
  end

  // --- result monitor ---
  always @(posedge clk) begin
    chunk_t e;
    if (!rst && m_tvalid && m_tready) begin
      if (chunk_q.size() == 0) begin
        $error("result word with nothing expected: tdata=%h", m_tdata);
        errors++;
      end else begin
        e = chunk_q.pop_front();
        if (m_tuser !== e.cv) begin
          $error("chunk_valid exp %0d got %0d", e.cv, m_tuser); errors++;
        end
        if (m_tdata[4:0] !== e.file) begin
          $error("chunk_file exp %0d got %0d", e.file, m_tdata[4:0]); errors++;
        end
        if (m_tdata[52:5] !== e.foff) begin
          $error("chunk_file_offset exp %0h got %0h", e.foff, m_tdata[52:5]); errors++;
        end
        if (m_tdata[84:53] !== e.len) begin
          $error("chunk_length exp %0d got %0d", e.len, m_tdata[84:53]); errors++;
        end
        if (m_tdata[116:85] !== e.boff) begin
          $error("chunk_buffer_offset exp %0d got %0d", e.boff, m_tdata[116:85]); errors++;
        end
        if (m_tdata[164:117] !== e.pos) begin
          $error("position exp %0h got %0h", e.pos, m_tdata[164:117]); errors++;
        end
        if (m_tdata[196:165] !== e.total) begin
          $error("total_bytes exp %0d got %0d", e.total, m_tdata[196:165]); errors++;
        end
        if (m_tdata[197] !== e.err) begin
          $error("walk_error exp %0d got %0d", e.err, m_tdata[197]); errors++;
        end
        if (m_tlast !== e.last) begin
          $error("last exp %0d got %0d", e.last, m_tlast); errors++;
        end
      end
    end
  end

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [63:0] val);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val[47:0];
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    if (idx == REG_TOTAL_LENGTH) stream_len = val & MASK48;
    else blk_count = val & 64'h7FF;
  endtask

  // Everything handed over and answered, then a margin for the block to settle.
  task automatic drain();
    while (pending_q.size() != 0 || s_tvalid || chunk_q.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);
  endtask

  // One table layout: load entries 0..nblk-1, then random traffic over it.
  // tl_sel: 0 stream ends at the last block, 1 short of it, 2 beyond it.
  task automatic run_layout(input int nblk, input logic [63:0] base, input int maxlen,
                            input int tl_sel, input int nrand, input bit stall);
    logic [63:0] pos_acc, tl;
    int          len, k, roll;
    item_t       it;
    logic [48:0] off;
    pos_acc = base;
    for (int j = 0; j < nblk; j++) begin
      if ($urandom_range(0, 9) == 0) pos_acc += $urandom_range(1, 40);   // hole
      len = ($urandom_range(0, 12) == 0) ? 0 : $urandom_range(1, maxlen);
      pending_q.push_back(mk_load(10'(j), 48'(pos_acc), 32'(len), 5'($urandom),
                                  48'(($urandom_range(0, 7) == 0) ? MASK48 - 3
                                                                  : 64'(rand48()))));
      pos_acc += 64'(len);
    end
    tl = (tl_sel == 1 && pos_acc > base + 2) ? pos_acc - $urandom_range(1, 2) :
         (tl_sel == 2) ? ((base == 0) ? pos_acc + 50 : MASK48) : pos_acc;
    drain();
    write_reg(REG_TOTAL_LENGTH, tl);
    write_reg(REG_BLOCK_COUNT, 64'(nblk));
    for (k = 0; k < nrand; k++) begin
      roll = $urandom_range(0, 99);
      if (stall && k == nrand / 2) hold_asked++;
      off = 49'(base + $urandom_range(0, 3 * maxlen * nblk / 2 + 8));
      if (roll < 8) begin
        it = junk_item(CMD_LOAD);   // noise load, outside the walked range
        it.idx = 10'($urandom_range(nblk, NTBL - 1));
        pending_q.push_back(it);
      end else if (roll < 12) begin
        it = junk_item(CMD_LOAD);   // rewrite a live entry's file mapping
        it.idx = 10'($urandom_range(0, nblk - 1));
        it.start = tbl_start[it.idx];
        it.len = tbl_len[it.idx];
        pending_q.push_back(it);
      end else if (roll < 24) begin
        if ($urandom_range(0, 1)) off = -49'($urandom_range(0, 3 * maxlen));
        pending_q.push_back(mk_seek(2'($urandom_range(0, 3)),
                            ($urandom_range(0, 2) == 0) ? 49'(off - base) : off));
      end else if (roll < 60) begin
        pending_q.push_back(mk_read(CMD_SEQ, '0,
                            ($urandom_range(0, 9) == 0) ? $urandom : $urandom_range(0, 2 * maxlen)));
      end else begin
        if ($urandom_range(0, 9) == 0) off = 49'({$urandom, $urandom});
        pending_q.push_back(mk_read(CMD_POS, off,
                            ($urandom_range(0, 9) == 0) ? $urandom : $urandom_range(0, 3 * maxlen)));
      end
    end
    drain();
  endtask

  initial begin
    errors = 0;
    calm = 1'b0;
    hold_asked = 0;
    cur_blk = 0;
    rd_pos = 0;
    stream_len = 0;
    blk_count = 0;
    rst = 1'b1;
    cfg_valid = 1'b0;
    cfg_index = REG_TOTAL_LENGTH;
    cfg_data = '0;
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // No blocks, full-size stream: every nonempty read inside the stream fails its walk.
    write_reg(REG_TOTAL_LENGTH, MASK48);
    write_reg(REG_BLOCK_COUNT, 0);
    pending_q.push_back(mk_load(10'd1023, 48'hFFFF_FFFF_FFFF, 32'hFFFF_FFFF, 5'd31,
                                48'hFFFF_FFFF_FFFF));
    pending_q.push_back(mk_load(10'd0, '0, '0, '0, '0));
    pending_q.push_back(mk_read(CMD_SEQ, '0, 32'hFFFF_FFFF));
    pending_q.push_back(mk_read(CMD_SEQ, '0, '0));
    pending_q.push_back(mk_read(CMD_POS, -49'sd5, 32'd10));        // negative clips to 0
    pending_q.push_back(mk_read(CMD_POS, 49'h0_FFFF_FFFF_FFFF, 32'd1));
    pending_q.push_back(mk_seek(SMODE_ABS, 49'd1234));
    pending_q.push_back(mk_seek(SMODE_REL, 49'h0_FFFF_FFFF_FFFF)); // saturates
    pending_q.push_back(mk_seek(SMODE_REL, 49'h0_FFFF_FFFF_FFFF));
    pending_q.push_back(mk_seek(SMODE_REL, -49'sd100));
    pending_q.push_back(mk_seek(SMODE_REL, 49'h1_0000_0000_0001)); // clips at 0
    pending_q.push_back(mk_seek(SMODE_BACK, 49'd7));
    pending_q.push_back(mk_seek(SMODE_BACK, -49'sd9));              // past the end saturates
    pending_q.push_back(mk_seek(SMODE_BACK, 49'h0_FFFF_FFFF_FFFF));
    pending_q.push_back(mk_seek(SMODE_RSVD, 49'd77));               // acts as from-start
    pending_q.push_back(mk_seek(SMODE_ABS, -49'sd1));
    pending_q.push_back(mk_read(CMD_SEQ, '0, 32'd3));
    drain();

    // Empty stream with the largest table size: reads only give status words.
    write_reg(REG_TOTAL_LENGTH, 0);
    write_reg(REG_BLOCK_COUNT, 64'(NTBL));
    pending_q.push_back(mk_read(CMD_SEQ, '0, 32'd100));
    pending_q.push_back(mk_read(CMD_POS, 49'd0, 32'hFFFF_FFFF));
    pending_q.push_back(mk_seek(SMODE_BACK, -49'sd3));
    pending_q.push_back(mk_read(CMD_SEQ, '0, 32'd1));
    drain();

    run_layout(8, 0, 3000, 0, 20, 1'b1);
    run_layout(1, 0, 500, 1, 8, 1'b0);           // cached block now stale
    calm = 1'b1;
    run_layout(16, MASK48 - 20000, 1000, 2, 10, 1'b0);
    calm = 1'b0;
    run_layout(12, 64'h8000, 200, 1, 10, 1'b1);

    if (errors == 0) $display("PASS scatter_gather_read_mapper");
    else $display("FAIL scatter_gather_read_mapper");
    $finish;
  end

endmodule
